[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the checker file cbps_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that also holds across reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/cbps_pkg.sv]
// ----------------------------------------------------------------------------
// cbps_pkg
// Types and constants shared by the pixel symbol classifier.
// ----------------------------------------------------------------------------
package cbps_pkg;

    // Symbol codes.
    localparam logic [2:0] SYM_WHITE = 3'd0;
    localparam logic [2:0] SYM_RED   = 3'd1;
    localparam logic [2:0] SYM_GREEN = 3'd2;
    localparam logic [2:0] SYM_BLUE  = 3'd3;
    localparam logic [2:0] SYM_BLACK = 3'd4;

    // Register map: register index taken from paddr[3:2].
    localparam int unsigned CFG_AW = 4;
    localparam logic [1:0] REG_DARK   = 2'd0;
    localparam logic [1:0] REG_CHROMA = 2'd1;
    localparam logic [1:0] REG_BRIGHT = 2'd2;
    localparam logic [1:0] REG_MARGIN = 2'd3;

    // Register reset values.
    localparam logic [7:0] RST_DARK   = 8'd70;
    localparam logic [7:0] RST_CHROMA = 8'd35;
    localparam logic [7:0] RST_BRIGHT = 8'd145;
    localparam logic [7:0] RST_MARGIN = 8'd25;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] dark_level;
        logic [7:0] gray_chroma_limit;
        logic [7:0] bright_level;
        logic [7:0] dominance_margin;
    } t_cfg;

    // Stage one: channels and their extremes.
    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] hi;
        logic [7:0] chroma;
        logic [7:0] max_gb;
        logic [7:0] max_rb;
        logic [7:0] max_rg;
    } t_feat;

    // Stage two: rule flags and palette scores. A score is the squared
    // distance to the color minus the distance to black, divided by 255.
    typedef struct packed {
        logic               black;
        logic               white;
        logic               dom_r;
        logic               dom_g;
        logic               dom_b;
        logic signed [10:0] e_white;
        logic signed [10:0] e_red;
        logic signed [10:0] e_green;
        logic signed [10:0] e_blue;
    } t_rule;

    // Stage three: rule outcome and two pairwise palette winners.
    typedef struct packed {
        logic               rule_hit;
        logic [2:0]         rule_sym;
        logic [2:0]         sym_a;
        logic signed [10:0] e_a;
        logic [2:0]         sym_b;
        logic signed [10:0] e_b;
    } t_part;

endpackage

[sv/cbps_front.sv]
// ----------------------------------------------------------------------------
// cbps_front
// First two pipeline stages: channel extremes, then rule flags and scores.
// ----------------------------------------------------------------------------
module cbps_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cbps_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_b,
    input  logic [7:0]     i_g,
    input  logic [7:0]     i_r,
    output logic           o_valid,
    input  logic           i_ready,
    output cbps_pkg::t_rule o_rule
);
    import cbps_pkg::*;

    logic  r_v1, r_v2;
    t_feat r_f1, n_f1;
    t_rule r_q2, n_q2;
    logic  w_rdy1, w_rdy2;
    logic [8:0]  w_sum_lo;
    logic [9:0]  w_sum;
    logic [11:0] w_e_white;

    // A stage takes a new item when it is empty or its item moves on.
    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage one: maxima of each channel pair, largest channel and chroma.
    always_comb begin
        logic [7:0] lo;
        n_f1.b      = i_b;
        n_f1.g      = i_g;
        n_f1.r      = i_r;
        n_f1.max_gb = (i_g > i_b) ? i_g : i_b;
        n_f1.max_rb = (i_r > i_b) ? i_r : i_b;
        n_f1.max_rg = (i_r > i_g) ? i_r : i_g;
        n_f1.hi     = (i_r > n_f1.max_gb) ? i_r : n_f1.max_gb;
        lo          = (i_g < i_b) ? i_g : i_b;
        lo          = (i_r < lo) ? i_r : lo;
        n_f1.chroma = n_f1.hi - lo;
    end

    // Stage two: threshold rules and linear palette scores.
    assign w_sum_lo  = {1'b0, r_f1.b} + {1'b0, r_f1.g};
    assign w_sum     = {1'b0, w_sum_lo} + {2'b00, r_f1.r};
    assign w_e_white = 12'sd765 - $signed({1'b0, w_sum, 1'b0});

    always_comb begin
        n_q2.black   = r_f1.hi < i_cfg.dark_level;
        n_q2.white   = (r_f1.chroma < i_cfg.gray_chroma_limit)
                       && (r_f1.hi > i_cfg.bright_level);
        n_q2.dom_r   = {1'b0, r_f1.r}
                       >= ({1'b0, r_f1.max_gb} + {1'b0, i_cfg.dominance_margin});
        n_q2.dom_g   = {1'b0, r_f1.g}
                       >= ({1'b0, r_f1.max_rb} + {1'b0, i_cfg.dominance_margin});
        n_q2.dom_b   = {1'b0, r_f1.b}
                       >= ({1'b0, r_f1.max_rg} + {1'b0, i_cfg.dominance_margin});
        n_q2.e_white = w_e_white[10:0];
        n_q2.e_red   = 11'sd255 - $signed({2'b00, r_f1.r, 1'b0});
        n_q2.e_green = 11'sd255 - $signed({2'b00, r_f1.g, 1'b0});
        n_q2.e_blue  = 11'sd255 - $signed({2'b00, r_f1.b, 1'b0});
    end

    // Valid bits for both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload registers load only when an item moves in.
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_f1 <= n_f1;
        end
        if (w_rdy2 && r_v1) begin
            r_q2 <= n_q2;
        end
    end

    assign o_valid = r_v2;
    assign o_rule  = r_q2;

endmodule

[sv/cbps_back.sv]
// ----------------------------------------------------------------------------
// cbps_back
// Last two pipeline stages: rule priority and nearest palette color search.
// ----------------------------------------------------------------------------
module cbps_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cbps_pkg::t_rule i_rule,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_sym
);
    import cbps_pkg::*;

    logic       r_v3, r_v4;
    t_part      r_p3, n_p3;
    logic [2:0] r_sym4, n_sym4;
    logic       w_rdy3, w_rdy4;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign o_ready = w_rdy3;

    // Stage three: rule priority and first round of the palette search.
    // On equal scores the earlier color in palette order is kept.
    always_comb begin
        n_p3.rule_hit = i_rule.black || i_rule.white || i_rule.dom_r
                        || i_rule.dom_g || i_rule.dom_b;
        if (i_rule.black) begin
            n_p3.rule_sym = SYM_BLACK;
        end else if (i_rule.white) begin
            n_p3.rule_sym = SYM_WHITE;
        end else if (i_rule.dom_r) begin
            n_p3.rule_sym = SYM_RED;
        end else if (i_rule.dom_g) begin
            n_p3.rule_sym = SYM_GREEN;
        end else begin
            n_p3.rule_sym = SYM_BLUE;
        end
        if (i_rule.e_red < i_rule.e_white) begin
            n_p3.sym_a = SYM_RED;
            n_p3.e_a   = i_rule.e_red;
        end else begin
            n_p3.sym_a = SYM_WHITE;
            n_p3.e_a   = i_rule.e_white;
        end
        if (i_rule.e_blue < i_rule.e_green) begin
            n_p3.sym_b = SYM_BLUE;
            n_p3.e_b   = i_rule.e_blue;
        end else begin
            n_p3.sym_b = SYM_GREEN;
            n_p3.e_b   = i_rule.e_green;
        end
    end

    // Stage four: a rule hit wins; else final palette round against black (score zero), which wins ties.
    always_comb begin
        logic [2:0]         sym_w;
        logic signed [10:0] e_w;
        if (r_p3.e_b < r_p3.e_a) begin
            sym_w = r_p3.sym_b;
            e_w   = r_p3.e_b;
        end else begin
            sym_w = r_p3.sym_a;
            e_w   = r_p3.e_a;
        end
        if (r_p3.rule_hit) begin
            n_sym4 = r_p3.rule_sym;
        end else if (e_w < 11'sd0) begin
            n_sym4 = sym_w;
        end else begin
            n_sym4 = SYM_BLACK;
        end
    end

    // Valid bits for both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy3) begin
                r_v3 <= i_valid;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) begin
            r_p3 <= n_p3;
        end
        if (w_rdy4 && r_v3) begin
            r_sym4 <= n_sym4;
        end
    end

    assign o_valid = r_v4;
    assign o_sym   = r_sym4;

endmodule

[sv/classify_bgr_pixel_to_symbol.sv]
// ----------------------------------------------------------------------------
// classify_bgr_pixel_to_symbol
// Classifies one BGR pixel into white, red, green, blue or black.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  pixel in  i_valid / o_ready      i_blue_level, i_green_level, i_red_level
//  symbol    o_valid / i_ready      o_symbol_code
//  config    psel/penable/pready    paddr, pwrite, pwdata, prdata
//
//  One pixel is taken every cycle unless the output stalls; its symbol passes
//  through the four register stages of the pipeline.
//  Reset (synchronous, active low) empties the pipeline and loads the
//  register defaults. A stall on the output holds every stage in place and
//  backs up to o_ready; an empty stage keeps taking items.
// ----------------------------------------------------------------------------
module classify_bgr_pixel_to_symbol (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_blue_level,
    input  logic [7:0]                 i_green_level,
    input  logic [7:0]                 i_red_level,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2:0]                 o_symbol_code,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cbps_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import cbps_pkg::*;

    t_cfg       r_cfg;
    t_rule      w_rule;
    logic       w_mid_valid, w_mid_ready;
    logic       w_wr;
    logic [1:0] w_idx;
    logic [7:0] w_rd;

    // Configuration registers.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_level        <= RST_DARK;
            r_cfg.gray_chroma_limit <= RST_CHROMA;
            r_cfg.bright_level      <= RST_BRIGHT;
            r_cfg.dominance_margin  <= RST_MARGIN;
        end else if (w_wr) begin
            case (w_idx)
                REG_DARK:   r_cfg.dark_level        <= pwdata[7:0];
                REG_CHROMA: r_cfg.gray_chroma_limit <= pwdata[7:0];
                REG_BRIGHT: r_cfg.bright_level      <= pwdata[7:0];
                REG_MARGIN: r_cfg.dominance_margin  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (w_idx)
            REG_DARK:   w_rd = r_cfg.dark_level;
            REG_CHROMA: w_rd = r_cfg.gray_chroma_limit;
            REG_BRIGHT: w_rd = r_cfg.bright_level;
            REG_MARGIN: w_rd = r_cfg.dominance_margin;
            default:    w_rd = 8'd0;
        endcase
    end
    assign prdata = {24'd0, w_rd};

    // Front half of the pipeline.
    cbps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_b     (i_blue_level),
        .i_g     (i_green_level),
        .i_r     (i_red_level),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_rule  (w_rule)
    );

    // Back half of the pipeline.
    cbps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mid_valid),
        .o_ready (w_mid_ready),
        .i_rule  (w_rule),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_sym   (o_symbol_code)
    );

endmodule

[sv/cbps_checker.sv]
// ----------------------------------------------------------------------------
// cbps_checker
// Port-level checks of the pixel symbol classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_symbol_code
);
    import cbps_pkg::*;

    // A held result keeps its symbol.
    `CHK_ASSERT(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_symbol_code), "output item changed while stalled")

    // Only the five symbol codes ever leave the block.
    `CHK_ASSERT(a_code, i_clk, i_rst_n, o_valid |-> o_symbol_code <= SYM_BLACK, "symbol code out of range")

    // Reset empties the pipeline.
    `CHK_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_valid, "output valid right after reset")

    // An empty output stage means no stage can be stalled.
    `CHK_ASSERT(a_ready, i_clk, i_rst_n, !o_valid |-> o_ready, "input stalled with an empty output stage")

    // With no output stall an item that enters reaches the output.
    `CHK_ASSERT(a_latency, i_clk, i_rst_n, (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready |=> o_valid, "item lost in the pipeline")

endmodule

bind classify_bgr_pixel_to_symbol cbps_checker u_cbps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_symbol_code (o_symbol_code)
);
